>>> hw/rtl/dq_pkg.sv
// Shared types and codes for the double-ended queue.
// Used by the queue top level; no dependencies.
package dq_pkg;

  // Operation requested by one request.
  typedef enum logic [1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_REAR  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_REAR   = 2'd3
  } kind_t;

  // Completion status reported with each result.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  localparam int unsigned ValueWidth = 32;

endpackage

>>> hw/rtl/dq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read; a read of the word being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/double_ended_queue.sv
// Double-ended queue top level: ring pointers, occupancy and result logic.
// Depends on dq_pkg and dq_ram.
//
// A request is taken at every clock edge where start is high; busy is never
// raised, so one request per cycle is sustained. Each request gets exactly
// one result, presented for a single cycle with done high, in the cycle after
// the request is taken: the entry store is a RAM with a registered read, and
// results line up with it. The receiver cannot stall results. A push into
// a full queue reports full, a pop from an empty queue reports empty, and in
// both cases the queue is left unchanged; pushes and errors return zero.
module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic signed [31:0] value,
  output logic        done,
  output logic signed [31:0] popped_value,
  output logic [1:0]  status
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCount = CW'(DEPTH);

  logic [AW-1:0] front_index;
  logic [AW-1:0] front_index_next;
  logic [AW-1:0] rear_index;
  logic [AW-1:0] rear_index_next;
  logic [CW-1:0] occupancy;
  logic [CW-1:0] occupancy_next;

  logic [AW-1:0] front_prev, front_succ, rear_prev, rear_succ;
  logic          accept, is_full, is_empty;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_rdata;
  dq_pkg::status_t status_d;
  dq_pkg::status_t status_q;
  logic          pop_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_full  = (occupancy == FullCount);
  assign is_empty = (occupancy == '0);

  // Neighbor slots with wrap at the end of the ring.
  assign front_prev = (front_index == '0) ? LastSlot : front_index - AW'(1);
  assign front_succ = (front_index == LastSlot) ? '0 : front_index + AW'(1);
  assign rear_prev  = (rear_index == '0) ? LastSlot : rear_index - AW'(1);
  assign rear_succ  = (rear_index == LastSlot) ? '0 : rear_index + AW'(1);

  // Decode the request into pointer moves and at most one memory access.
  always_comb begin
    front_index_next = front_index;
    rear_index_next  = rear_index;
    occupancy_next   = occupancy;
    mem_we           = 1'b0;
    mem_re           = 1'b0;
    mem_waddr        = rear_index;
    mem_raddr        = front_index;
    status_d         = dq_pkg::ST_OK;
    if (accept) begin
      unique case (dq_pkg::kind_t'(kind))
        dq_pkg::KIND_PUSH_FRONT: begin
          if (is_full) begin
            status_d = dq_pkg::ST_FULL;
          end else begin
            front_index_next = front_prev;
            mem_we           = 1'b1;
            mem_waddr        = front_prev;
            occupancy_next   = occupancy + CW'(1);
          end
        end
        dq_pkg::KIND_PUSH_REAR: begin
          if (is_full) begin
            status_d = dq_pkg::ST_FULL;
          end else begin
            rear_index_next = rear_succ;
            mem_we          = 1'b1;
            mem_waddr       = rear_index;
            occupancy_next  = occupancy + CW'(1);
          end
        end
        dq_pkg::KIND_POP_FRONT: begin
          if (is_empty) begin
            status_d = dq_pkg::ST_EMPTY;
          end else begin
            front_index_next = front_succ;
            mem_re           = 1'b1;
            mem_raddr        = front_index;
            occupancy_next   = occupancy - CW'(1);
          end
        end
        dq_pkg::KIND_POP_REAR: begin
          if (is_empty) begin
            status_d = dq_pkg::ST_EMPTY;
          end else begin
            rear_index_next = rear_prev;
            mem_re          = 1'b1;
            mem_raddr       = rear_prev;
            occupancy_next  = occupancy - CW'(1);
          end
        end
        default: begin
          status_d = dq_pkg::ST_OK;
        end
      endcase
    end
  end

  // Pointer and count registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      rear_index  <= '0;
      occupancy   <= '0;
    end else begin
      front_index <= front_index_next;
      rear_index  <= rear_index_next;
      occupancy   <= occupancy_next;
    end
  end

  // Result stage: lines up with the read data of the entry store.
  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= 1'b0;
      pop_q    <= 1'b0;
      status_q <= dq_pkg::ST_OK;
    end else begin
      done     <= accept;
      pop_q    <= mem_re;
      status_q <= status_d;
    end
  end

  dq_ram #(
    .WIDTH(dq_pkg::ValueWidth),
    .DEPTH(DEPTH)
  ) u_entries (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(value),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign popped_value = pop_q ? mem_rdata : '0;
  assign status       = status_q;

  // The count never passes the ring size.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= FullCount)
    else $error("occupancy exceeds depth");

  // Every request yields exactly one result on the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("result missing after request");

  // Without a request the count holds.
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(occupancy) && !done)
    else $error("state changed without a request");

  // A full report only comes from a full queue.
  a_full_cause: assert property (@(posedge clk) disable iff (rst)
    done && status_q == dq_pkg::ST_FULL |-> $past(occupancy) == FullCount)
    else $error("full reported on a queue with room");

  // A successful pop removes exactly one element.
  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    done && pop_q |-> occupancy == $past(occupancy) - CW'(1))
    else $error("pop did not decrement occupancy");

endmodule
